// ----- design/pls_pkg.sv -----
// Shared types, constants and control structs of the pillar layer subdivider.
package pls_pkg;

  localparam int DEPTH_W     = 32;
  localparam int FACTOR_W    = 6;
  localparam int TOL_W       = 10;
  localparam int MAX_REFINE  = 63;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [DEPTH_W-1:0] depth_t;
  typedef logic [FACTOR_W-1:0]       factor_t;
  typedef logic [TOL_W-1:0]          tol_t;

  // Classified layer segment, passed from front to back through the queue.
  typedef struct packed {
    depth_t               top;
    depth_t               bot;
    logic [DEPTH_W-1:0]   mag;   // |bottom - top|
    logic                 neg;   // bottom below top
    factor_t              factor;
    logic                 act;
    logic                 fin;
  } pls_entry_t;

  typedef struct packed {
    logic               start;
    logic [DEPTH_W-1:0] dividend;
    factor_t            divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DEPTH_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SUB,
    S_BOT,
    S_ERR
  } pls_state_e;

endpackage

// ----- design/pls_if.sv -----
// Channel interfaces: layer input, result output and tolerance write port.
interface pls_in_if;
  logic               valid;
  logic               ready;
  pls_pkg::depth_t    top_depth;
  pls_pkg::depth_t    bottom_depth;
  pls_pkg::factor_t   refine_factor;
  logic               cell_active;
  logic               final_layer;

  modport source (output valid, top_depth, bottom_depth, refine_factor, cell_active,
                  final_layer, input ready);
  modport sink   (input valid, top_depth, bottom_depth, refine_factor, cell_active,
                  final_layer, output ready);
endinterface

interface pls_out_if;
  logic               valid;
  logic               ready;
  pls_pkg::depth_t    depth;
  logic               sub_active;
  logic               is_bottom;
  logic               thickness_error;
  logic               run_end;

  modport source (output valid, depth, sub_active, is_bottom, thickness_error, run_end,
                  input ready);
  modport sink   (input valid, depth, sub_active, is_bottom, thickness_error, run_end,
                  output ready);
endinterface

interface pls_cfg_if;
  logic            valid;
  logic            ready;
  pls_pkg::tol_t   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- design/pillar_layer_subdivider.sv -----
// Flow: an item with factor F > 0 leaves the queue, goes through serial division (one
//   quotient bit a cycle), then F beats, plus one bottom beat if final, or one error
//   beat instead if the step fails the tolerance check. A new item is taken only when
//   the last is done; a factor-zero final gives a bottom beat, a halted item an error
//   beat, a factor-zero inner layer none. Reset (async, active low) clears the queue,
//   the halted flag, the tolerance and the output valid; there is no clearing pass.
// Top level of the pillar layer subdivider.
module pillar_layer_subdivider #(
  parameter int QueueDepth = pls_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pls_in_if.sink     in_i,
  pls_cfg_if.sink    cfg_i,
  pls_out_if.source  out_o
);
  import pls_pkg::*;

  // Front classifies each layer beat: factor saturated, 33-bit thickness split into
  // sign and magnitude for the divider.
  pls_entry_t  front_entry, queue_entry;
  logic        push, full, pop, empty;

  pls_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (front_entry)
  );

  // Short queue lets the front keep taking beats while the back divides or is stalled.
  pls_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .empty_o (empty)
  );

  // Back owns the halted flag and the tolerance register, runs the divider and
  // walks the accumulator top + n*step into the output register.
  pls_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (queue_entry),
    .pop_o   (pop),
    .cfg_i   (cfg_i),
    .out_o   (out_o)
  );

endmodule

// ----- design/pls_front.sv -----
// Front end: accepts layer beats, saturates the factor and forms the thickness.
module pls_front (
  pls_in_if.sink               in_i,
  input  logic                 full_i,
  output logic                 push_o,
  output pls_pkg::pls_entry_t  entry_o
);
  import pls_pkg::*;

  logic signed [DEPTH_W:0] diff;

  assign diff = {in_i.bottom_depth[DEPTH_W-1], in_i.bottom_depth}
              - {in_i.top_depth[DEPTH_W-1], in_i.top_depth};

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    entry_o.top = in_i.top_depth;
    entry_o.bot = in_i.bottom_depth;
    entry_o.neg = diff[DEPTH_W];
    // magnitude of a 33-bit difference always fits in 32 bits
    entry_o.mag = diff[DEPTH_W] ? DEPTH_W'(-diff) : diff[DEPTH_W-1:0];
    entry_o.factor = (in_i.refine_factor > FACTOR_W'(MAX_REFINE)) ?
                     FACTOR_W'(MAX_REFINE) : in_i.refine_factor;
    entry_o.act = in_i.cell_active;
    entry_o.fin = in_i.final_layer;
  end

endmodule

// ----- design/pls_queue.sv -----
// Short FIFO of classified entries between front and back.
module pls_queue #(
  parameter int Depth = pls_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pls_pkg::pls_entry_t  entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output pls_pkg::pls_entry_t  entry_o,
  output logic                 empty_o
);
  import pls_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pls_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- design/pls_div.sv -----
// Restoring divider: 32-bit magnitude by 6-bit factor, one quotient bit a cycle.
module pls_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pls_pkg::div_req_t  req_i,
  output pls_pkg::div_rsp_t  rsp_o
);
  import pls_pkg::*;

  localparam int CntW = $clog2(DEPTH_W);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [FACTOR_W-1:0]  rem_q, div_q, rem_d;
  logic [DEPTH_W-1:0]   quo_q;
  logic [FACTOR_W:0]    trial;
  logic                 ge;

  assign trial = {rem_q, quo_q[DEPTH_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign rem_d = ge ? FACTOR_W'(trial - {1'b0, div_q}) : trial[FACTOR_W-1:0];

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DEPTH_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      div_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DEPTH_W-2:0], ge};
    end
  end

endmodule

// ----- design/pls_back.sv -----
// Back end: runs the division, checks the step and emits the sub-layer, bottom and error beats.
module pls_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  pls_pkg::pls_entry_t  entry_i,
  output logic                 pop_o,
  pls_cfg_if.sink              cfg_i,
  pls_out_if.source            out_o
);
  import pls_pkg::*;

  pls_state_e          state_q, state_d;
  pls_entry_t          ent_q;
  logic                halted_q, halted_d;
  tol_t                tol_q;
  logic signed [DEPTH_W:0] step_q, step_d, acc_q, acc_d, quo_s;
  factor_t             cnt_q, cnt_d;
  logic                slot_free, load, last_sub;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // output register
  logic                ov_q, ov_d;
  depth_t              od_q, od_d;
  logic                oa_q, oa_d, ob_q, ob_d, oe_q, oe_d, or_q, or_d;

  pls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_i.ready = 1'b1;
  assign slot_free   = !ov_q || out_o.ready;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign last_sub    = (cnt_q == ent_q.factor - FACTOR_W'(1));
  assign quo_s       = {1'b0, div_rsp.quotient};

  assign div_req.start    = pop_o && !halted_q && (entry_i.factor != '0);
  assign div_req.dividend = entry_i.mag;
  assign div_req.divisor  = entry_i.factor;

  assign out_o.valid           = ov_q;
  assign out_o.depth           = od_q;
  assign out_o.sub_active      = oa_q;
  assign out_o.is_bottom       = ob_q;
  assign out_o.thickness_error = oe_q;
  assign out_o.run_end         = or_q;

  always_comb begin
    state_d  = state_q;
    halted_d = halted_q;
    step_d   = step_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    load     = 1'b0;
    od_d     = od_q;
    oa_d     = oa_q;
    ob_d     = ob_q;
    oe_d     = oe_q;
    or_d     = or_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (halted_q) begin
            state_d = S_ERR;
          end else if (entry_i.factor != '0) begin
            state_d = S_DIV;
          end else if (entry_i.fin) begin
            state_d = S_BOT;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          step_d = ent_q.neg ? -quo_s : quo_s;
          if (step_d < -$signed({{(DEPTH_W+1-TOL_W){1'b0}}, tol_q})) begin
            halted_d = 1'b1;
            state_d  = S_ERR;
          end else begin
            acc_d   = {ent_q.top[DEPTH_W-1], ent_q.top};
            cnt_d   = '0;
            state_d = S_SUB;
          end
        end
      end
      S_SUB: begin
        if (slot_free) begin
          load  = 1'b1;
          od_d  = acc_q[DEPTH_W-1:0];
          oa_d  = ent_q.act;
          ob_d  = 1'b0;
          oe_d  = 1'b0;
          or_d  = last_sub && !ent_q.fin;
          acc_d = acc_q + step_q;
          cnt_d = cnt_q + FACTOR_W'(1);
          if (last_sub) begin
            state_d = ent_q.fin ? S_BOT : S_IDLE;
          end
        end
      end
      S_BOT: begin
        if (slot_free) begin
          load    = 1'b1;
          od_d    = ent_q.bot;
          oa_d    = 1'b0;
          ob_d    = 1'b1;
          oe_d    = 1'b0;
          or_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          load    = 1'b1;
          od_d    = '0;
          oa_d    = 1'b0;
          ob_d    = 1'b0;
          oe_d    = 1'b1;
          or_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    ov_d = load || (ov_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      halted_q <= 1'b0;
      tol_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      halted_q <= halted_d;
      ov_q     <= ov_d;
      if (cfg_i.valid) begin
        tol_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
    step_q <= step_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    od_q   <= od_d;
    oa_q   <= oa_d;
    ob_q   <= ob_d;
    oe_q   <= oe_d;
    or_q   <= or_d;
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared without reset");

  a_err_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oe_q) |-> halted_q)
    else $error("error beat while not halted");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB) |-> (cnt_q < ent_q.factor))
    else $error("sub-layer count past factor");

  a_bottom_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ob_q) |-> or_q)
    else $error("bottom beat not closing its run");

endmodule
